### hw/rtl/rcst_pkg.sv
// ----------------------------------------------------------------------------
// rcst_pkg
// Shared types and codes of the reference-counted slot table: request and
// response payloads, operation and status codes, and the controller commands.
// ----------------------------------------------------------------------------
package rcst_pkg;

    // Default table geometry.
    localparam int DEF_SLOTS      = 64;
    localparam int DEF_COUNT_BITS = 16;

    // Fixed field widths of the request and response.
    localparam int OP_W      = 2;
    localparam int ID_W      = 6;
    localparam int STATUS_W  = 2;
    localparam int RSP_CNT_W = 16;

    // Configuration register: number of slots that allocation may use.
    localparam int             CFG_W     = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Free-slot search works on groups of this many slots.
    localparam int GRP_SIZE = 8;
    localparam int GRP_POS_W = 3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CREATE_FAIL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT    = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic [ID_W-1:0] slot_id;
        logic            auto_free;
        logic            backend_ok;
    } rcst_req_t;

    typedef struct packed {
        logic [ID_W-1:0]      result_slot;
        logic [STATUS_W-1:0]  status;
        logic [RSP_CNT_W-1:0] ref_count_now;
        logic                 slot_freed;
    } rcst_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;  // capture a new request
        logic read;  // read the slot entry and sample the free-slot groups
        logic exec;  // update the table and register the response
    } rcst_cmd_t;

endpackage

### hw/rtl/rcst_free_find.sv
// ----------------------------------------------------------------------------
// rcst_free_find
// Two-level search for the lowest free slot below the allocation limit.
// The first level is registered per group of slots; the second picks the
// lowest group that holds a free slot.
// ----------------------------------------------------------------------------
module rcst_free_find
    import rcst_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
)(
    input  logic             clk,
    input  logic             sample,
    input  logic [SLOTS-1:0] valid_bits,
    input  logic [CFG_W-1:0] limit,
    output logic             found,
    output logic [IDX_W-1:0] free_idx
);

    localparam int NGRP   = (SLOTS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PAD    = NGRP * GRP_SIZE;
    localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;

    logic [PAD-1:0]       free_vec;
    logic [NGRP-1:0]      grp_any_next;
    logic [GRP_POS_W-1:0] grp_pos_next [NGRP];
    logic [NGRP-1:0]      grp_any_reg;
    logic [GRP_POS_W-1:0] grp_pos_reg  [NGRP];
    logic [GSEL_W-1:0]    grp_sel;

    // A slot is a candidate when it is free and below the allocation limit.
    for (genvar i = 0; i < PAD; i++) begin : g_free
        if (i < SLOTS) begin : g_real
            assign free_vec[i] = !valid_bits[i] && (32'(i) < 32'(limit));
        end
        else begin : g_pad
            assign free_vec[i] = 1'b0;
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGRP; g++) begin
            grp_any_next[g] = |free_vec[g*GRP_SIZE +: GRP_SIZE];
            grp_pos_next[g] = '0;
            for (int b = GRP_SIZE - 1; b >= 0; b--) begin
                if (free_vec[g*GRP_SIZE + b]) begin
                    grp_pos_next[g] = GRP_POS_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample) begin
            grp_any_reg <= grp_any_next;
            for (int g = 0; g < NGRP; g++) begin
                grp_pos_reg[g] <= grp_pos_next[g];
            end
        end
    end

    always_comb
    begin
        grp_sel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_any_reg[g]) begin
                grp_sel = GSEL_W'(g);
            end
        end
    end

    assign found    = |grp_any_reg;
    assign free_idx = IDX_W'((32'(grp_sel) << GRP_POS_W) | 32'(grp_pos_reg[grp_sel]));

endmodule

### hw/rtl/rcst_datapath.sv
// ----------------------------------------------------------------------------
// rcst_datapath
// Slot storage and update logic: valid bits, the count and auto-release
// memory, the free-slot search, the configuration register and the
// registered response.
// ----------------------------------------------------------------------------
module rcst_datapath
    import rcst_pkg::*;
#(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)(
    input  logic             clk,
    input  logic             rst_n,
    input  rcst_cmd_t        cmd,
    input  rcst_req_t        req,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    output rcst_rsp_t        rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WORD_W = COUNT_BITS + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    rcst_req_t        req_reg;
    rcst_rsp_t        rsp_reg;
    rcst_rsp_t        rsp_next;
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    logic [CFG_W-1:0] limit_reg;
    logic [WORD_W-1:0] rd_data_reg;

    // Entry word: auto-release flag above the reference count.
    logic [WORD_W-1:0] slot_mem [SLOTS];

    logic             found;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] id_idx;
    logic             id_ok;
    logic             live;
    logic [COUNT_BITS-1:0] cnt;
    logic                  aut;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;

    rcst_free_find #(
        .SLOTS (SLOTS)
    ) u_free_find (
        .clk        (clk),
        .sample     (cmd.read),
        .valid_bits (valid_reg),
        .limit      (limit_reg),
        .found      (found),
        .free_idx   (free_idx)
    );

    assign id_idx  = IDX_W'(req_reg.slot_id);
    assign id_ok   = 32'(req_reg.slot_id) < 32'(SLOTS);
    assign live    = id_ok && valid_reg[id_idx];
    assign cnt     = rd_data_reg[COUNT_BITS-1:0];
    assign aut     = rd_data_reg[COUNT_BITS];
    assign cnt_inc = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
    assign cnt_dec = (cnt == '0) ? cnt : cnt - 1'b1;

    always_comb
    begin
        rsp_next   = '0;
        valid_next = valid_reg;
        wr_en      = 1'b0;
        wr_addr    = id_idx;
        wr_data    = rd_data_reg;
        case (req_reg.opcode)
            OP_ALLOC:
            begin
                if (!found) begin
                    rsp_next.status = ST_FULL;
                end
                else if (!req_reg.backend_ok) begin
                    // The slot was free and stays free.
                    rsp_next.status = ST_CREATE_FAIL;
                end
                else begin
                    wr_en                  = 1'b1;
                    wr_addr                = free_idx;
                    wr_data                = {req_reg.auto_free, COUNT_BITS'(1)};
                    valid_next[free_idx]   = 1'b1;
                    rsp_next.result_slot   = ID_W'(free_idx);
                    rsp_next.ref_count_now = RSP_CNT_W'(1);
                end
            end
            OP_ACQUIRE:
            begin
                if (!live) begin
                    rsp_next.status = ST_BAD_SLOT;
                end
                else begin
                    wr_en                  = 1'b1;
                    wr_data                = {aut, cnt_inc};
                    rsp_next.result_slot   = req_reg.slot_id;
                    rsp_next.ref_count_now = RSP_CNT_W'(cnt_inc);
                end
            end
            OP_RELEASE:
            begin
                if (!live) begin
                    rsp_next.status = ST_BAD_SLOT;
                end
                else if (cnt_dec == '0 && aut) begin
                    // The entry word is left stale; it is rewritten on allocation.
                    valid_next[id_idx]   = 1'b0;
                    rsp_next.result_slot = req_reg.slot_id;
                    rsp_next.slot_freed  = 1'b1;
                end
                else begin
                    wr_en                  = 1'b1;
                    wr_data                = {aut, cnt_dec};
                    rsp_next.result_slot   = req_reg.slot_id;
                    rsp_next.ref_count_now = RSP_CNT_W'(cnt_dec);
                end
            end
            default:
            begin
                rsp_next.status = ST_BAD_SLOT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            limit_reg <= CFG_RESET;
        end
        else begin
            if (cmd.exec) begin
                valid_reg <= valid_next;
            end
            if (cfg_we) begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            req_reg <= req;
        end
        if (cmd.exec) begin
            rsp_reg <= rsp_next;
        end
    end

    // Slot memory: one read and one write port, registered read data.
    always_ff @(posedge clk)
    begin
        if (cmd.read) begin
            rd_data_reg <= slot_mem[id_idx];
        end
        if (cmd.exec && wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    assign rsp = rsp_reg;

endmodule

### hw/rtl/rcst_ctrl.sv
// ----------------------------------------------------------------------------
// rcst_ctrl
// Controller of the slot table: sequences each request through a read state
// and an execute state, and raises the response strobe.
// ----------------------------------------------------------------------------
module rcst_ctrl
    import rcst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output rcst_cmd_t cmd,
    output logic      rsp_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   accept;

    assign busy   = (state_reg == S_READ);
    assign accept = start && !busy;

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_READ : S_IDLE;
            S_READ:  state_next = S_EXEC;
            S_EXEC:  state_next = accept ? S_READ : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            rsp_valid_reg <= (state_reg == S_EXEC);
        end
    end

    assign cmd.load  = accept;
    assign cmd.read  = (state_reg == S_READ);
    assign cmd.exec  = (state_reg == S_EXEC);
    assign rsp_valid = rsp_valid_reg;

endmodule

### hw/rtl/refcounted_slot_table.sv
// ----------------------------------------------------------------------------
// refcounted_slot_table
// Table of reference-counted slots with allocate, acquire and release.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and its response
// appears on rsp for exactly one cycle, flagged by rsp_valid, once the
// request has passed the read and execute states; the receiver cannot stall
// it, so it must capture the response in that cycle. Each request first
// reads the addressed slot's count from the slot memory and registers the
// per-group free-slot search, then updates the slot and registers the
// response. A new request may be issued in the cycle in which the previous
// one executes. The allocation limit is written through the cfg port, which
// is always ready; write it only while no request is in flight. There is no
// clearing pass after reset: valid marks clear at once and slot counts are
// written before they are ever read.
// ----------------------------------------------------------------------------
module refcounted_slot_table
    import rcst_pkg::*;
#(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rcst_req_t        req,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    output logic             rsp_valid,
    output rcst_rsp_t        rsp
);

    rcst_cmd_t cmd;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    // The controller sequences each request; it sees no datapath status,
    // since every request passes through the same states.
    rcst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .rsp_valid (rsp_valid)
    );

    // The datapath holds the slot state and forms the response.
    rcst_datapath #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .rsp      (rsp)
    );

endmodule

### hw/rtl/rcst_checker.sv
// ----------------------------------------------------------------------------
// rcst_checker
// Port-level checks of the slot table's request timing and response fields.
// ----------------------------------------------------------------------------
module rcst_checker
    import rcst_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             rsp_valid,
    input rcst_rsp_t        rsp
);

    // A taken request makes the block busy for exactly one cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy next cycle");

    a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // Every taken request is followed by its response strobe.
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 rsp_valid)
        else $error("response missing after a request");

    // An error response carries no slot and no count.
    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_OK) |->
            (rsp.result_slot == '0 && rsp.ref_count_now == '0 && !rsp.slot_freed))
        else $error("error response with nonzero fields");

    // A freed slot reports a zero count with status ok.
    a_freed_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.slot_freed) |->
            (rsp.status == ST_OK && rsp.ref_count_now == '0))
        else $error("freed slot response with bad fields");

endmodule

bind refcounted_slot_table rcst_checker u_checker (.*);

### tb/sv/refcounted_slot_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_slot_table_tb
// Self-checking testbench for the reference-counted slot table. A directed
// table covers the special cases. Random traffic then runs under several
// allocation limits with the sender idling at different rates. Each response
// is compared with a typed-in answer or with a behavioral model of the table.
// ----------------------------------------------------------------------------
module refcounted_slot_table_tb;
    import rcst_pkg::*;

    // Opcode 3 is not defined by the block and must be rejected.
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    // Run limits. The cycle limit lies far above the length of a correct run,
    // even at the highest idle rate.
    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned RAND_REQS   = 295;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    rcst_req_t        req = '0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             rsp_valid;
    rcst_rsp_t        rsp;

    refcounted_slot_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    always #5ns clk = ~clk;

    // ------------------------------------------------------------------------
    // Behavioral model of the table. The state is updated at the clock edge
    // that accepts a request, so the model always sees requests in the same
    // order as the block does.
    // ------------------------------------------------------------------------
    logic                 slot_live     [DEF_SLOTS];
    logic [RSP_CNT_W-1:0] slot_cnt      [DEF_SLOTS];
    logic                 slot_autofree [DEF_SLOTS];
    logic [CFG_W-1:0]     alloc_limit;

    // Responses still owed by the block, oldest first.
    rcst_rsp_t   pending_rsp[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    // Applies one request to the model and returns the response it should
    // produce.
    function automatic rcst_rsp_t table_apply(rcst_req_t r);
        rcst_rsp_t   o;
        int unsigned lim;
        int unsigned i;
        o = '0;
        // A limit above the table size behaves like the table size.
        lim = (alloc_limit > DEF_SLOTS) ? DEF_SLOTS : alloc_limit;
        if (r.opcode == OP_ALLOC)
        begin
            // Lowest free slot below the limit; a zero limit always fails.
            i = 0;
            while (i < lim && slot_live[i])
                i++;
            if (i >= lim)
            begin
                o.status = ST_FULL;
            end
            else if (!r.backend_ok)
            begin
                // The backend failed, so the slot goes straight back to free.
                slot_live[i]     = 1'b0;
                slot_cnt[i]      = '0;
                slot_autofree[i] = 1'b0;
                o.status         = ST_CREATE_FAIL;
            end
            else
            begin
                slot_live[i]     = 1'b1;
                slot_cnt[i]      = RSP_CNT_W'(1);
                slot_autofree[i] = r.auto_free;
                o.result_slot    = ID_W'(i);
                o.status         = ST_OK;
                o.ref_count_now  = RSP_CNT_W'(1);
            end
        end
        else if ((r.opcode != OP_ACQUIRE && r.opcode != OP_RELEASE)
                 || !slot_live[r.slot_id])
        begin
            // Unknown opcodes and free slots are rejected. A slot id past the
            // table cannot occur here, since the id field spans the table.
            o.status = ST_BAD_SLOT;
        end
        else if (r.opcode == OP_ACQUIRE)
        begin
            // The count sticks at its largest value.
            if (slot_cnt[r.slot_id] != '1)
                slot_cnt[r.slot_id] = slot_cnt[r.slot_id] + 1'b1;
            o.result_slot   = r.slot_id;
            o.status        = ST_OK;
            o.ref_count_now = slot_cnt[r.slot_id];
        end
        else
        begin
            if (slot_cnt[r.slot_id] != '0)
                slot_cnt[r.slot_id] = slot_cnt[r.slot_id] - 1'b1;
            o.result_slot = r.slot_id;
            o.status      = ST_OK;
            if (slot_cnt[r.slot_id] == '0 && slot_autofree[r.slot_id])
            begin
                slot_live[r.slot_id]     = 1'b0;
                slot_autofree[r.slot_id] = 1'b0;
                o.slot_freed             = 1'b1;
            end
            else
            begin
                // Without auto-release the slot stays valid, even at zero.
                o.ref_count_now = slot_cnt[r.slot_id];
            end
        end
        return o;
    endfunction

    // Builds a random request. Most acquire and release requests address a
    // slot that is currently valid, so that counts climb, fall and free
    // slots; the rest hit arbitrary slots and exercise the rejection path.
    function automatic rcst_req_t make_request();
        rcst_req_t   r;
        int unsigned roll;
        int unsigned live_ids[$];
        for (int s = 0; s < DEF_SLOTS; s++)
        begin
            if (slot_live[s])
                live_ids.push_back(s);
        end
        roll = $urandom_range(99);
        if (roll < 30)
            r.opcode = OP_ALLOC;
        else if (roll < 62)
            r.opcode = OP_ACQUIRE;
        else if (roll < 95)
            r.opcode = OP_RELEASE;
        else
            r.opcode = OP_UNKNOWN;
        if (live_ids.size() != 0 && $urandom_range(99) < 85)
            r.slot_id = ID_W'(live_ids[$urandom_range(live_ids.size() - 1)]);
        else
            r.slot_id = ID_W'($urandom_range(DEF_SLOTS - 1));
        r.auto_free  = ($urandom_range(99) < 75);
        r.backend_ok = ($urandom_range(99) < 85);
        return r;
    endfunction

    // Picks an allocation limit, with the extremes coming up often.
    function automatic logic [CFG_W-1:0] pick_limit();
        case ($urandom_range(7))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'(DEF_SLOTS);
            3:       return '1;
            4:       return CFG_W'($urandom_range(8, 2));
            default: return CFG_W'($urandom_range(DEF_SLOTS, 1));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. The sender idles for a random number of cycles, then
    // holds start high until a clock edge finds busy low. The model runs at
    // that edge. Start is left high on return so that back-to-back requests
    // keep it high without a glitch; the next call or a drain lowers it.
    // ------------------------------------------------------------------------
    task automatic send_request(input rcst_req_t r, input int unsigned idle_pct,
                                input bit typed, input rcst_rsp_t typed_rsp);
        rcst_rsp_t guess;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        guess = table_apply(r);
        // For rows whose answer is plain from the spec, the typed-in value is
        // what the block is held to; the model still tracks the state.
        pending_rsp.push_back(typed ? typed_rsp : guess);
    endtask

    // Stops sending and waits until every owed response has arrived. It
    // always waits for a clock edge, so start is never assigned twice in
    // one time step.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
    endtask

    // Writes the allocation limit. Callers drain first, so the block is idle.
    task automatic write_limit(input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        alloc_limit = v;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Directed table. Each row is either a limit write or a request; request
    // rows with an answer that is obvious from the spec carry it typed in,
    // the others are checked against the model.
    // ------------------------------------------------------------------------
    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] limit;
        rcst_req_t        rq;
        bit               typed;
        rcst_rsp_t        answer;
    } step_row_t;

    step_row_t directed[$];

    function automatic step_row_t req_row(logic [OP_W-1:0] op, int unsigned id,
                                          bit au, bit ok);
        step_row_t row;
        row.is_cfg = 1'b0;
        row.limit  = '0;
        row.rq     = '{opcode: op, slot_id: ID_W'(id), auto_free: au,
                       backend_ok: ok};
        row.typed  = 1'b0;
        row.answer = '0;
        return row;
    endfunction

    function automatic step_row_t typed_row(logic [OP_W-1:0] op, int unsigned id,
                                            bit au, bit ok, int unsigned slot,
                                            logic [STATUS_W-1:0] st,
                                            int unsigned cnt, bit freed);
        step_row_t row;
        row        = req_row(op, id, au, ok);
        row.typed  = 1'b1;
        row.answer = '{result_slot: ID_W'(slot), status: st,
                       ref_count_now: RSP_CNT_W'(cnt), slot_freed: freed};
        return row;
    endfunction

    function automatic step_row_t cfg_row(int unsigned v);
        step_row_t row;
        row        = req_row(OP_ALLOC, 0, 1'b0, 1'b0);
        row.is_cfg = 1'b1;
        row.limit  = CFG_W'(v);
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Response checker. A response is valid for exactly one cycle and the
    // receiver cannot stall it, so it is taken at every edge that sees
    // rsp_valid high.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rcst_rsp_t want;
        if (rst_n && rsp_valid)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response with no request outstanding: slot %0d status %0d",
                       rsp.result_slot, rsp.status);
                mismatches++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.result_slot !== want.result_slot)
                begin
                    $error("result_slot: expected %0d, got %0d",
                           want.result_slot, rsp.result_slot);
                    mismatches++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    mismatches++;
                end
                if (rsp.ref_count_now !== want.ref_count_now)
                begin
                    $error("ref_count_now: expected %0d, got %0d",
                           want.ref_count_now, rsp.ref_count_now);
                    mismatches++;
                end
                if (rsp.slot_freed !== want.slot_freed)
                begin
                    $error("slot_freed: expected %0d, got %0d",
                           want.slot_freed, rsp.slot_freed);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a hung handshake or a lost response ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned idle_rates[3];

        for (int s = 0; s < DEF_SLOTS; s++)
        begin
            slot_live[s]     = 1'b0;
            slot_cnt[s]      = '0;
            slot_autofree[s] = 1'b0;
        end
        alloc_limit = CFG_RESET;

        // Reset is asserted once, here, and never again.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fresh table: everything free, limit at its reset value.
        directed.push_back(typed_row(OP_ACQUIRE, 0, 1'b0, 1'b1, 0, ST_BAD_SLOT, 0, 1'b0));
        directed.push_back(typed_row(OP_RELEASE, 63, 1'b1, 1'b1, 0, ST_BAD_SLOT, 0, 1'b0));
        directed.push_back(typed_row(OP_UNKNOWN, 0, 1'b0, 1'b0, 0, ST_BAD_SLOT, 0, 1'b0));
        directed.push_back(typed_row(OP_ALLOC, 0, 1'b0, 1'b1, 0, ST_OK, 1, 1'b0));
        // Creation failure hands back slot 1 untouched.
        directed.push_back(typed_row(OP_ALLOC, 0, 1'b1, 1'b0, 0, ST_CREATE_FAIL, 0, 1'b0));
        directed.push_back(typed_row(OP_ALLOC, 63, 1'b1, 1'b1, 1, ST_OK, 1, 1'b0));
        // Slot 0 has no auto-release: count goes up, down to zero and stays.
        directed.push_back(req_row(OP_ACQUIRE, 0, 1'b0, 1'b0));
        directed.push_back(req_row(OP_RELEASE, 0, 1'b0, 1'b0));
        directed.push_back(req_row(OP_RELEASE, 0, 1'b0, 1'b0));
        directed.push_back(req_row(OP_RELEASE, 0, 1'b1, 1'b1));
        directed.push_back(req_row(OP_ACQUIRE, 0, 1'b0, 1'b0));
        // Slot 1 has auto-release: the release to zero frees it.
        directed.push_back(req_row(OP_RELEASE, 1, 1'b0, 1'b0));
        directed.push_back(req_row(OP_ACQUIRE, 1, 1'b0, 1'b0));
        directed.push_back(typed_row(OP_UNKNOWN, 63, 1'b1, 1'b1, 0, ST_BAD_SLOT, 0, 1'b0));
        // A zero limit makes every allocate report a full table.
        directed.push_back(cfg_row(0));
        directed.push_back(typed_row(OP_ALLOC, 0, 1'b1, 1'b1, 0, ST_FULL, 0, 1'b0));
        // A limit above the table size acts as the table size.
        directed.push_back(cfg_row(127));
        directed.push_back(req_row(OP_ALLOC, 0, 1'b1, 1'b1));
        directed.push_back(req_row(OP_ALLOC, 0, 1'b0, 1'b1));
        // Lowering the limit blocks allocation but not slots above it.
        directed.push_back(cfg_row(1));
        directed.push_back(typed_row(OP_ALLOC, 0, 1'b1, 1'b1, 0, ST_FULL, 0, 1'b0));
        directed.push_back(req_row(OP_ACQUIRE, 2, 1'b0, 1'b0));
        directed.push_back(req_row(OP_RELEASE, 1, 1'b0, 1'b0));
        directed.push_back(cfg_row(64));

        foreach (directed[k])
        begin
            if (directed[k].is_cfg)
            begin
                drain();
                write_limit(directed[k].limit);
            end
            else
            begin
                send_request(directed[k].rq, 38, directed[k].typed,
                             directed[k].answer);
            end
        end

        // Random traffic in three phases: the sender idles often, then very
        // often, then never. The limit changes every 60 requests while the
        // block is idle, and now and then the sender waits for the pipeline
        // to empty before the next request.
        idle_rates = '{38, 77, 0};
        foreach (idle_rates[p])
        begin
            for (int unsigned n = 0; n < RAND_REQS; n++)
            begin
                if (n % 60 == 0)
                begin
                    drain();
                    write_limit(pick_limit());
                end
                else if ($urandom_range(99) < 2)
                begin
                    drain();
                end
                send_request(make_request(), idle_rates[p], 1'b0, '0);
            end
        end

        // Let the last responses arrive, then keep the clock running so that
        // any stray response would still be caught.
        drain();
        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
hw/rtl/rcst_pkg.sv
hw/rtl/rcst_free_find.sv
hw/rtl/rcst_datapath.sv
hw/rtl/rcst_ctrl.sv
hw/rtl/refcounted_slot_table.sv
hw/rtl/rcst_checker.sv
tb/sv/refcounted_slot_table_tb.sv
